// File: sv/cpualu_pkg.sv
// Package for the 8-bit CPU ALU with flags: operation codes, flag bit
// positions and the beat structs used by the pipeline. No dependencies.
package cpualu_pkg;

  localparam int unsigned OpW    = 6;
  localparam int unsigned WordW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned BitIdxW = 3;
  localparam int unsigned FlagW  = 4;

  // Flag bit positions
  localparam int unsigned FZ = 3;
  localparam int unsigned FN = 2;
  localparam int unsigned FH = 1;
  localparam int unsigned FC = 0;

  // Operation codes
  localparam logic [OpW-1:0] OP_ADD    = 6'd0;
  localparam logic [OpW-1:0] OP_ADC    = 6'd1;
  localparam logic [OpW-1:0] OP_SUB    = 6'd2;
  localparam logic [OpW-1:0] OP_SBC    = 6'd3;
  localparam logic [OpW-1:0] OP_AND    = 6'd4;
  localparam logic [OpW-1:0] OP_XOR    = 6'd5;
  localparam logic [OpW-1:0] OP_OR     = 6'd6;
  localparam logic [OpW-1:0] OP_CP     = 6'd7;
  localparam logic [OpW-1:0] OP_INC    = 6'd8;
  localparam logic [OpW-1:0] OP_DEC    = 6'd9;
  localparam logic [OpW-1:0] OP_DAA    = 6'd10;
  localparam logic [OpW-1:0] OP_CPL    = 6'd11;
  localparam logic [OpW-1:0] OP_SCF    = 6'd12;
  localparam logic [OpW-1:0] OP_CCF    = 6'd13;
  localparam logic [OpW-1:0] OP_RLCA   = 6'd14;
  localparam logic [OpW-1:0] OP_RRCA   = 6'd15;
  localparam logic [OpW-1:0] OP_RLA    = 6'd16;
  localparam logic [OpW-1:0] OP_RRA    = 6'd17;
  localparam logic [OpW-1:0] OP_RLC    = 6'd18;
  localparam logic [OpW-1:0] OP_RRC    = 6'd19;
  localparam logic [OpW-1:0] OP_RL     = 6'd20;
  localparam logic [OpW-1:0] OP_RR     = 6'd21;
  localparam logic [OpW-1:0] OP_SLA    = 6'd22;
  localparam logic [OpW-1:0] OP_SRA    = 6'd23;
  localparam logic [OpW-1:0] OP_SWAP   = 6'd24;
  localparam logic [OpW-1:0] OP_SRL    = 6'd25;
  localparam logic [OpW-1:0] OP_BIT    = 6'd26;
  localparam logic [OpW-1:0] OP_RES    = 6'd27;
  localparam logic [OpW-1:0] OP_SET    = 6'd28;
  localparam logic [OpW-1:0] OP_ADD16  = 6'd29;
  localparam logic [OpW-1:0] OP_ADDOFS = 6'd30;
  localparam logic [OpW-1:0] OP_INC16  = 6'd31;
  localparam logic [OpW-1:0] OP_DEC16  = 6'd32;

  typedef struct packed {
    logic [OpW-1:0]     operation;
    logic [WordW-1:0]   first_operand;
    logic [WordW-1:0]   second_operand;
    logic [BitIdxW-1:0] bit_index;
    logic [FlagW-1:0]   flags_in;
  } item_t;

  typedef struct packed {
    logic [WordW-1:0] result;
    logic [FlagW-1:0] flags_out;
  } res_t;

endpackage

// File: sv/cpualu_if.sv
// Valid/ready channel interfaces for the CPU ALU: operation beats in,
// result beats out. Depends on cpualu_pkg.
interface cpualu_in_if
  import cpualu_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [OpW-1:0]     operation;
  logic [WordW-1:0]   first_operand;
  logic [WordW-1:0]   second_operand;
  logic [BitIdxW-1:0] bit_index;
  logic [FlagW-1:0]   flags_in;

  modport source (
    output valid, operation, first_operand, second_operand, bit_index, flags_in,
    input  ready
  );
  modport sink (
    input  valid, operation, first_operand, second_operand, bit_index, flags_in,
    output ready
  );
endinterface

interface cpualu_out_if
  import cpualu_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [WordW-1:0] result;
  logic [FlagW-1:0] flags_out;

  modport source (
    output valid, result, flags_out,
    input  ready
  );
  modport sink (
    input  valid, result, flags_out,
    output ready
  );
endinterface

// File: sv/cpu_alu_with_flags.sv
// Top level of the 8-bit CPU ALU with flags: input register, execute logic,
// result register. Depends on cpualu_pkg, cpualu_if and cpualu_exec.
//
// The block takes one operation beat per clock while input ready is high
// and returns one result beat per operation, in order. A beat is latched
// into the input register, evaluated by the execute logic (8-bit
// add/subtract with half carry, logic, rotates, shifts, decimal adjust,
// bit ops, 16-bit add and signed offset add) and captured in the result
// register. Both registers advance independently, so a new operation is
// taken while a finished result still waits for the sink; a full pipeline
// holds two operations and input ready drops only when both stages are
// occupied and the sink is not taking the result. There is no
// configuration and no state kept between operations.
module cpu_alu_with_flags
  import cpualu_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  cpualu_in_if.sink         in_i,
  cpualu_out_if.source      out_o
);

  // stage 1: operand register
  logic  s1_valid_q, s1_valid_d;
  item_t s1_q;
  // stage 2: result register
  logic  out_valid_q, out_valid_d;
  res_t  out_q, exec_res;

  logic  in_fire, s1_adv, in_ready;

  assign s1_adv   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !s1_valid_q || s1_adv;
  assign in_fire  = in_i.valid && in_ready;

  assign s1_valid_d  = in_fire || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.operation      <= in_i.operation;
      s1_q.first_operand  <= in_i.first_operand;
      s1_q.second_operand <= in_i.second_operand;
      s1_q.bit_index      <= in_i.bit_index;
      s1_q.flags_in       <= in_i.flags_in;
    end
    if (s1_adv) begin
      out_q <= exec_res;
    end
  end

  cpualu_exec u_exec (
    .item_i (s1_q),
    .res_o  (exec_res)
  );

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.result    = out_q.result;
  assign out_o.flags_out = out_q.flags_out;

  // accepted beat always lands in stage 1
  a_fill_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted beat not held in stage 1");

  // stage 1 beat is not dropped while the result register is blocked
  a_hold_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_o.ready) |=> s1_valid_q)
    else $error("stage 1 beat lost under stall");

  // no result appears without a stage 1 beat behind it
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && !s1_valid_q) |=> !out_valid_q)
    else $error("result beat without source");

  // byte logic ops leave the upper result byte clear
  a_byte_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && (s1_q.operation == OP_AND || s1_q.operation == OP_XOR ||
                s1_q.operation == OP_OR)) |=> (out_q.result[15:8] == 8'd0))
    else $error("byte op upper result byte not zero");

endmodule

// File: sv/cpualu_exec.sv
// Combinational execute logic of the CPU ALU: one registered operation beat
// in, result and flags out. Depends on cpualu_pkg.
module cpualu_exec
  import cpualu_pkg::*;
(
  input  item_t item_i,
  output res_t  res_o
);

  logic [ByteW-1:0] a, v, mask;
  logic [WordW-1:0] w, v16, off16, r;
  logic [FlagW-1:0] f, fo;
  logic             c, ci, zf;
  logic [8:0]       add9, sub9, daa1, daa_add, offc9;
  logic [4:0]       addh5, subh5, offh5;
  logic [7:0]       daa_s1, daa_sub;
  logic             daa_lo, daa_hi;
  logic [16:0]      add17;
  logic [12:0]      h13;

  always_comb begin
    w    = item_i.first_operand;
    v16  = item_i.second_operand;
    a    = w[7:0];
    v    = v16[7:0];
    f    = item_i.flags_in;
    c    = f[FC];
    ci   = ((item_i.operation == OP_ADC) || (item_i.operation == OP_SBC)) ? c : 1'b0;
    mask = 8'h01 << item_i.bit_index;

    add9  = {1'b0, a} + {1'b0, v} + {8'd0, ci};
    addh5 = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, ci};
    sub9  = {1'b0, a} - {1'b0, v} - {8'd0, ci};
    subh5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, ci};

    // decimal adjust, add and subtract paths
    daa_lo  = f[FH] || (a[3:0] > 4'd9);
    daa1    = {1'b0, a} + (daa_lo ? 9'h006 : 9'h000);
    daa_hi  = c || (daa1 > 9'h09F);
    daa_add = daa1 + (daa_hi ? 9'h060 : 9'h000);
    daa_s1  = a - (f[FH] ? 8'h06 : 8'h00);
    daa_sub = daa_s1 - (c ? 8'h60 : 8'h00);

    add17 = {1'b0, w} + {1'b0, v16};
    h13   = {1'b0, w[11:0]} + {1'b0, v16[11:0]};
    off16 = {{8{v[7]}}, v};
    offh5 = {1'b0, w[3:0]} + {1'b0, v[3:0]};
    offc9 = {1'b0, w[7:0]} + {1'b0, v};

    r  = w;
    fo = f;
    zf = 1'b0;

    case (item_i.operation)
      OP_ADD, OP_ADC: begin
        r      = {8'd0, add9[7:0]};
        fo[FH] = addh5[4];
        fo[FC] = add9[8];
        fo[FN] = 1'b0;
        zf     = 1'b1;
      end
      OP_SUB, OP_SBC, OP_CP: begin
        fo[FH] = subh5[4];
        fo[FC] = sub9[8];
        fo[FN] = 1'b1;
        fo[FZ] = (sub9[7:0] == 8'd0);
        r      = (item_i.operation == OP_CP) ? w : {8'd0, sub9[7:0]};
      end
      OP_AND: begin
        r  = {8'd0, a & v};
        fo = 4'b0010;
        zf = 1'b1;
      end
      OP_XOR: begin
        r  = {8'd0, a ^ v};
        fo = 4'b0000;
        zf = 1'b1;
      end
      OP_OR: begin
        r  = {8'd0, a | v};
        fo = 4'b0000;
        zf = 1'b1;
      end
      OP_INC: begin
        r      = {8'd0, a + 8'd1};
        fo[FN] = 1'b0;
        fo[FH] = (r[3:0] == 4'h0);
        zf     = 1'b1;
      end
      OP_DEC: begin
        r      = {8'd0, a - 8'd1};
        fo[FN] = 1'b1;
        fo[FH] = (r[3:0] == 4'hF);
        zf     = 1'b1;
      end
      OP_DAA: begin
        if (!f[FN]) begin
          r = {8'd0, daa_add[7:0]};
          if (daa_hi) fo[FC] = 1'b1;
        end else begin
          r = {8'd0, daa_sub};
        end
        fo[FH] = 1'b0;
        zf     = 1'b1;
      end
      OP_CPL: begin
        r      = {8'd0, ~a};
        fo[FN] = 1'b1;
        fo[FH] = 1'b1;
      end
      OP_SCF: begin
        r      = {8'd0, a};
        fo[FN] = 1'b0;
        fo[FH] = 1'b0;
        fo[FC] = 1'b1;
      end
      OP_CCF: begin
        r      = {8'd0, a};
        fo[FN] = 1'b0;
        fo[FH] = 1'b0;
        fo[FC] = ~c;
      end
      OP_RLCA, OP_RLC: begin
        r  = {8'd0, a[6:0], a[7]};
        fo = {3'b000, a[7]};
        zf = (item_i.operation == OP_RLC);
      end
      OP_RRCA, OP_RRC: begin
        r  = {8'd0, a[0], a[7:1]};
        fo = {3'b000, a[0]};
        zf = (item_i.operation == OP_RRC);
      end
      OP_RLA, OP_RL: begin
        r  = {8'd0, a[6:0], c};
        fo = {3'b000, a[7]};
        zf = (item_i.operation == OP_RL);
      end
      OP_RRA, OP_RR: begin
        r  = {8'd0, c, a[7:1]};
        fo = {3'b000, a[0]};
        zf = (item_i.operation == OP_RR);
      end
      OP_SLA: begin
        r  = {8'd0, a[6:0], 1'b0};
        fo = {3'b000, a[7]};
        zf = 1'b1;
      end
      OP_SRA: begin
        r  = {8'd0, a[7], a[7:1]};
        fo = {3'b000, a[0]};
        zf = 1'b1;
      end
      OP_SWAP: begin
        r  = {8'd0, a[3:0], a[7:4]};
        fo = 4'b0000;
        zf = 1'b1;
      end
      OP_SRL: begin
        r  = {8'd0, 1'b0, a[7:1]};
        fo = {3'b000, a[0]};
        zf = 1'b1;
      end
      OP_BIT: begin
        r      = w;
        fo[FZ] = ((a & mask) == 8'd0);
        fo[FN] = 1'b0;
        fo[FH] = 1'b1;
      end
      OP_RES: r = {8'd0, a & ~mask};
      OP_SET: r = {8'd0, a | mask};
      OP_ADD16: begin
        r      = add17[15:0];
        fo[FN] = 1'b0;
        fo[FH] = h13[12];
        fo[FC] = add17[16];
      end
      OP_ADDOFS: begin
        r  = w + off16;
        fo = {2'b00, offh5[4], offc9[8]};
      end
      OP_INC16: r = w + 16'd1;
      OP_DEC16: r = w - 16'd1;
      default: begin
        r  = w;
        fo = f;
      end
    endcase

    if (zf) fo[FZ] = (r == 16'd0);

    res_o.result    = r;
    res_o.flags_out = fo;
  end

endmodule

// File: bench/tb_cpu_alu_with_flags.sv
// Self-checking bench for cpu_alu_with_flags: directed and random operation beats
// are predicted by an in-bench ALU model and checked in order against result beats.
// Depends on cpualu_pkg, cpualu_if and the cpu_alu_with_flags RTL.
module tb_cpu_alu_with_flags;
  timeunit 1ns;
  timeprecision 1ps;

  import cpualu_pkg::*;

  // Run shape
  localparam int unsigned RandOps    = 1850;
  localparam int unsigned MaxIdle    = 13;
  localparam int unsigned HoldAtBeat = 500;   // result beat count where the long hold-off starts
  localparam int unsigned HoldCycles = 150;   // long enough to back up both pipeline stages
  localparam int unsigned DrainWait  = 8;     // pipeline is two deep; a few spare cycles

  // Flag masks built from the package bit positions
  localparam logic [FlagW-1:0] ZF = 4'(1) << FZ;
  localparam logic [FlagW-1:0] NF = 4'(1) << FN;
  localparam logic [FlagW-1:0] HF = 4'(1) << FH;
  localparam logic [FlagW-1:0] CF = 4'(1) << FC;

  // Holds predicted result beats in issue order and checks the DUT against them.
  class alu_scoreboard;
    res_t        pending_results[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Bit-exact ALU: one operation beat in, one result beat out.
    function res_t alu_eval(item_t op_beat);
      logic [WordW-1:0] w, v16, r, ofs;
      logic [ByteW-1:0] a, v, r8, t8;
      logic [FlagW-1:0] f;
      logic             c, ci, zfree;
      logic [ByteW:0]   t9;
      logic [4:0]       h5;
      logic [12:0]      h13;
      logic [WordW:0]   t17;
      res_t             o;
      w     = op_beat.first_operand;
      v16   = op_beat.second_operand;
      a     = w[ByteW-1:0];
      v     = v16[ByteW-1:0];
      f     = op_beat.flags_in;
      c     = f[FC];
      r     = w;
      zfree = 1'b0;
      case (op_beat.operation)
        OP_ADD, OP_ADC: begin
          ci    = (op_beat.operation == OP_ADC) ? c : 1'b0;
          t9    = {1'b0, a} + {1'b0, v} + ci;
          h5    = {1'b0, a[3:0]} + {1'b0, v[3:0]} + ci;
          f[FH] = h5[4];
          f[FC] = t9[ByteW];
          f[FN] = 1'b0;
          r     = {8'h00, t9[ByteW-1:0]};
          zfree = 1'b1;
        end
        OP_SUB, OP_SBC, OP_CP: begin
          // CP computes flags like SUB but hands the operand back whole
          ci    = (op_beat.operation == OP_SBC) ? c : 1'b0;
          f[FH] = {1'b0, a[3:0]} < ({1'b0, v[3:0]} + ci);
          f[FC] = {1'b0, a} < ({1'b0, v} + ci);
          f[FN] = 1'b1;
          t8    = a - v - ci;
          f[FZ] = (t8 == 8'h00);
          r     = (op_beat.operation == OP_CP) ? w : {8'h00, t8};
        end
        OP_AND: begin
          r     = {8'h00, a & v};
          f     = HF;
          zfree = 1'b1;
        end
        OP_XOR: begin
          r     = {8'h00, a ^ v};
          f     = '0;
          zfree = 1'b1;
        end
        OP_OR: begin
          r     = {8'h00, a | v};
          f     = '0;
          zfree = 1'b1;
        end
        OP_INC: begin
          r8    = a + 8'd1;
          r     = {8'h00, r8};
          f[FN] = 1'b0;
          f[FH] = (r8[3:0] == 4'h0);
          zfree = 1'b1;
        end
        OP_DEC: begin
          r8    = a - 8'd1;
          r     = {8'h00, r8};
          f[FN] = 1'b1;
          f[FH] = (r8[3:0] == 4'hF);
          zfree = 1'b1;
        end
        OP_DAA: begin
          if (!f[FN]) begin
            // after an add: carry set only when the high correction goes in
            t9 = {1'b0, a};
            if (f[FH] || a[3:0] > 4'd9) t9 = t9 + 9'h006;
            if (c || t9 > 9'h09F) begin
              t9    = t9 + 9'h060;
              f[FC] = 1'b1;
            end
            r = {8'h00, t9[ByteW-1:0]};
          end else begin
            // after a subtract: carry stays as it came
            t8 = a;
            if (f[FH]) t8 = t8 - 8'h06;
            if (c) t8 = t8 - 8'h60;
            r = {8'h00, t8};
          end
          f[FH] = 1'b0;
          zfree = 1'b1;
        end
        OP_CPL: begin
          r     = {8'h00, ~a};
          f     = f | NF | HF;
        end
        OP_SCF: begin
          r     = {8'h00, a};
          f     = (f & ~(NF | HF)) | CF;
        end
        OP_CCF: begin
          r     = {8'h00, a};
          f     = (f & ~(NF | HF)) ^ CF;
        end
        // accumulator rotates always leave Z clear
        OP_RLCA: begin r = {8'h00, a[6:0], a[7]}; f = {3'b000, a[7]}; end
        OP_RRCA: begin r = {8'h00, a[0], a[7:1]}; f = {3'b000, a[0]}; end
        OP_RLA:  begin r = {8'h00, a[6:0], c};    f = {3'b000, a[7]}; end
        OP_RRA:  begin r = {8'h00, c, a[7:1]};    f = {3'b000, a[0]}; end
        // prefixed forms take Z from the result
        OP_RLC:  begin r = {8'h00, a[6:0], a[7]};  f = {3'b000, a[7]}; zfree = 1'b1; end
        OP_RRC:  begin r = {8'h00, a[0], a[7:1]};  f = {3'b000, a[0]}; zfree = 1'b1; end
        OP_RL:   begin r = {8'h00, a[6:0], c};     f = {3'b000, a[7]}; zfree = 1'b1; end
        OP_RR:   begin r = {8'h00, c, a[7:1]};     f = {3'b000, a[0]}; zfree = 1'b1; end
        OP_SLA:  begin r = {8'h00, a[6:0], 1'b0};  f = {3'b000, a[7]}; zfree = 1'b1; end
        OP_SRA:  begin r = {8'h00, a[7], a[7:1]};  f = {3'b000, a[0]}; zfree = 1'b1; end
        OP_SWAP: begin r = {8'h00, a[3:0], a[7:4]}; f = '0;            zfree = 1'b1; end
        OP_SRL:  begin r = {8'h00, 1'b0, a[7:1]};  f = {3'b000, a[0]}; zfree = 1'b1; end
        OP_BIT: begin
          r     = w;
          f[FN] = 1'b0;
          f[FH] = 1'b1;
          f[FZ] = ~a[op_beat.bit_index];
        end
        OP_RES: begin
          r8                    = a;
          r8[op_beat.bit_index] = 1'b0;
          r                     = {8'h00, r8};
        end
        OP_SET: begin
          r8                    = a;
          r8[op_beat.bit_index] = 1'b1;
          r                     = {8'h00, r8};
        end
        OP_ADD16: begin
          t17   = {1'b0, w} + {1'b0, v16};
          h13   = {1'b0, w[11:0]} + {1'b0, v16[11:0]};
          f[FN] = 1'b0;
          f[FH] = h13[12];
          f[FC] = t17[WordW];
          r     = t17[WordW-1:0];
        end
        OP_ADDOFS: begin
          // signed byte offset; H and C come from the unsigned low-byte add
          ofs   = {{8{v[7]}}, v};
          r     = w + ofs;
          h5    = {1'b0, w[3:0]} + {1'b0, v[3:0]};
          t9    = {1'b0, w[ByteW-1:0]} + {1'b0, v};
          f     = '0;
          f[FH] = h5[4];
          f[FC] = t9[ByteW];
        end
        OP_INC16: r = w + 16'd1;
        OP_DEC16: r = w - 16'd1;
        default: ;
      endcase
      if (zfree) f[FZ] = (r == '0);
      o.result    = r;
      o.flags_out = f;
      return o;
    endfunction

    function void note_issue(item_t op_beat);
      pending_results.push_back(alu_eval(op_beat));
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing pending: result=%h flags=%h",
                 $time, got.result, got.flags_out);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.result !== want.result) begin
        $display("%0t: result mismatch: expected %h, got %h", $time, want.result, got.result);
        errors++;
      end
      if (got.flags_out !== want.flags_out) begin
        $display("%0t: flags mismatch: expected %b, got %b",
                 $time, want.flags_out, got.flags_out);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  cpualu_in_if  in_bus ();
  cpualu_out_if out_bus ();

  cpu_alu_with_flags DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  alu_scoreboard scoreboard = new();

  // When set, the operation driver sends back to back with no idle cycles
  bit burst;

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Returns interesting 16-bit values more often than plain random ones:
  // word edges, nibble/byte carry points and BCD-ish low bytes under a random
  // upper byte (which the 8-bit operations must ignore).
  function automatic logic [WordW-1:0] pick_word();
    logic [WordW-1:0] word_edges [13];
    logic [ByteW-1:0] byte_edges [13];
    word_edges = '{16'h0000, 16'h0001, 16'h000F, 16'h0010, 16'h007F, 16'h0080, 16'h00FF,
                   16'h0FFF, 16'h1000, 16'h7FFF, 16'h8000, 16'hFFFE, 16'hFFFF};
    byte_edges = '{8'h00, 8'h01, 8'h09, 8'h0A, 8'h0F, 8'h10, 8'h7F,
                   8'h80, 8'h99, 8'h9F, 8'hA0, 8'hF0, 8'hFF};
    case ($urandom_range(0, 4))
      0, 1:    return 16'($urandom_range(0, 16'hFFFF));
      2:       return word_edges[$urandom_range(0, 12)];
      3:       return {8'($urandom_range(0, 255)), byte_edges[$urandom_range(0, 12)]};
      default: return {8'($urandom_range(0, 255)), 8'($urandom_range(0, 31))};
    endcase
  endfunction

  // Sends one operation beat. Entered and left at a falling edge, so payload
  // and valid change only there; valid is written once per falling edge.
  task automatic issue(input logic [OpW-1:0] op, input logic [WordW-1:0] w,
                       input logic [WordW-1:0] v, input logic [BitIdxW-1:0] bi,
                       input logic [FlagW-1:0] f);
    int unsigned gap;
    item_t       op_beat;
    gap = burst ? 0 : $urandom_range(0, MaxIdle);
    if (gap != 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    op_beat.operation      = op;
    op_beat.first_operand  = w;
    op_beat.second_operand = v;
    op_beat.bit_index      = bi;
    op_beat.flags_in       = f;
    in_bus.operation       = op;
    in_bus.first_operand   = w;
    in_bus.second_operand  = v;
    in_bus.bit_index       = bi;
    in_bus.flags_in        = f;
    in_bus.valid           = 1'b1;
    do @(posedge clk_i); while (!in_bus.ready);
    scoreboard.note_issue(op_beat);
    @(negedge clk_i);
  endtask

  // Every operation at least once, with operands that land on its corner cases.
  task automatic run_directed();
    issue(OP_ADD,    16'h000F, 16'h0001, 3'd0, 4'h0);        // half carry
    issue(OP_ADD,    16'hFFFF, 16'hFF01, 3'd0, ZF | NF);     // wraps to zero, carry
    issue(OP_ADC,    16'h00FF, 16'h0000, 3'd0, CF);          // carry in makes zero
    issue(OP_SUB,    16'h0010, 16'h0001, 3'd0, 4'h0);        // nibble borrow
    issue(OP_SBC,    16'h0000, 16'h00FF, 3'd7, CF);          // full borrow with carry in
    issue(OP_AND,    16'h00F0, 16'h000F, 3'd0, CF);          // zero result
    issue(OP_XOR,    16'hAAAA, 16'h55AA, 3'd0, 4'hF);
    issue(OP_OR,     16'h0000, 16'h0000, 3'd0, 4'hF);
    issue(OP_CP,     16'hAB3C, 16'h003C, 3'd0, 4'h0);        // word back untouched, Z set
    issue(OP_INC,    16'h12FF, 16'h0000, 3'd0, NF | CF);     // upper byte must clear
    issue(OP_DEC,    16'h0000, 16'h0000, 3'd0, 4'h0);        // nibble borrow
    issue(OP_DEC,    16'h0001, 16'h0000, 3'd0, CF);          // zero
    issue(OP_DAA,    16'h009A, 16'h0000, 3'd0, 4'h0);        // both corrections, carry out
    issue(OP_DAA,    16'h00FF, 16'h0000, 3'd0, NF | HF | CF); // after subtract
    issue(OP_CPL,    16'h005A, 16'h0000, 3'd0, ZF | CF);
    issue(OP_SCF,    16'h0033, 16'h0000, 3'd0, NF | HF);
    issue(OP_CCF,    16'h0033, 16'h0000, 3'd0, ZF | CF);
    issue(OP_RLCA,   16'h0000, 16'h0000, 3'd0, ZF);          // zero result, Z still clear
    issue(OP_RRCA,   16'h0001, 16'h0000, 3'd0, 4'h0);
    issue(OP_RLA,    16'h0080, 16'h0000, 3'd0, 4'h0);        // zero result, Z still clear
    issue(OP_RRA,    16'h0001, 16'h0000, 3'd0, CF);
    issue(OP_RLC,    16'h0000, 16'h0000, 3'd0, 4'h0);        // prefixed form sets Z
    issue(OP_RRC,    16'h0001, 16'h0000, 3'd0, 4'h0);
    issue(OP_RL,     16'h0080, 16'h0000, 3'd0, 4'h0);
    issue(OP_RR,     16'h0001, 16'h0000, 3'd0, CF);
    issue(OP_SLA,    16'h0080, 16'h0000, 3'd0, 4'h0);
    issue(OP_SRA,    16'h0081, 16'h0000, 3'd0, 4'h0);
    issue(OP_SWAP,   16'h00F0, 16'h0000, 3'd0, CF);
    issue(OP_SRL,    16'h0001, 16'h0000, 3'd0, 4'h0);
    issue(OP_BIT,    16'hFF7F, 16'h0000, 3'd7, CF);          // tested bit clear
    issue(OP_RES,    16'hFFFF, 16'h0000, 3'd7, 4'hF);
    issue(OP_SET,    16'hFF00, 16'h0000, 3'd0, 4'h0);
    issue(OP_ADD16,  16'h0FFF, 16'h0001, 3'd0, ZF | NF);     // carry out of bit 11
    issue(OP_ADD16,  16'hFFFF, 16'h0001, 3'd0, 4'h0);        // carry out of bit 15
    issue(OP_ADDOFS, 16'h0000, 16'hFFFF, 3'd0, 4'hF);        // minus one
    issue(OP_ADDOFS, 16'h00FF, 16'h0001, 3'd0, 4'h0);        // low-byte carries
    issue(OP_INC16,  16'hFFFF, 16'h0000, 3'd0, 4'hA);
    issue(OP_DEC16,  16'h0000, 16'h0000, 3'd0, 4'h5);
  endtask

  // Result side: random stalls per beat, stall-free stretches, and one long
  // hold-off that lets the pipeline fill and drop input ready.
  initial begin : result_sink
    int unsigned stall;
    int unsigned beats;
    res_t        got;
    beats         = 0;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (beats == HoldAtBeat) stall = HoldCycles;
      else if ((beats / 150) % 4 == 2) stall = 0;
      else stall = $urandom_range(0, MaxIdle);
      if (stall != 0) begin
        out_bus.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_bus.ready = 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
      got.result    = out_bus.result;
      got.flags_out = out_bus.flags_out;
      scoreboard.check_result(got);
      beats++;
      @(negedge clk_i);
    end
  end

  // Main sequence: reset, directed beats, random beats, drain, verdict.
  initial begin : op_driver
    rst_ni                = 1'b0;
    burst                 = 1'b0;
    in_bus.valid          = 1'b0;
    in_bus.operation      = OP_ADD;
    in_bus.first_operand  = '0;
    in_bus.second_operand = '0;
    in_bus.bit_index      = '0;
    in_bus.flags_in       = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    run_directed();

    // Random beats; every fourth block of 200 goes back to back.
    for (int n = 0; n < RandOps; n++) begin
      burst = ((n / 200) % 4 == 1);
      issue(OpW'($urandom_range(0, OP_DEC16)), pick_word(), pick_word(),
            BitIdxW'($urandom_range(0, 7)), FlagW'($urandom_range(0, 15)));
    end
    in_bus.valid = 1'b0;

    // Let every predicted beat come back, then watch a few more cycles for strays.
    while (scoreboard.pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (scoreboard.errors == 0 && scoreboard.pending_results.size() == 0) begin
      $display("** cpu_alu_with_flags: PASSED **");
    end else begin
      $display("** cpu_alu_with_flags: FAILED **");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin : watchdog
    #6_000_000;
    $display("** cpu_alu_with_flags: FAILED **");
    $finish;
  end

endmodule
